// File: hdl/bfx_pkg.sv
// Shared constants for the BF op execution core: operation codes and field widths.
// No dependencies; imported by the top level.
package bfx_pkg;

    localparam int CMD_W   = 4;
    localparam int ARG_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 15;
    localparam int PC_W    = 16;
    localparam int DPOUT_W = 15;

    localparam logic [CMD_W-1:0] CMD_INVALID = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PTR_INC = 4'd1;
    localparam logic [CMD_W-1:0] CMD_PTR_DEC = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ADD     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_SUB     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_READ    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_ZERO    = 4'd7;
    localparam logic [CMD_W-1:0] CMD_SCAN    = 4'd8;
    localparam logic [CMD_W-1:0] CMD_MOVE    = 4'd9;
    localparam logic [CMD_W-1:0] CMD_JZ      = 4'd10;
    localparam logic [CMD_W-1:0] CMD_JNZ     = 4'd11;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

// File: hdl/bfx_ptr_unit.sv
// Shared pointer step unit: moves a tape pointer forward or backward by a reduced
// offset, wrapping modulo the tape size. No package dependencies.
module bfx_ptr_unit #(
    parameter int TAPE_CELLS = 32768
) (
    input  logic [$clog2(TAPE_CELLS)-1:0] base,
    input  logic [$clog2(TAPE_CELLS)-1:0] offset,
    input  logic                          backward,
    output logic [$clog2(TAPE_CELLS)-1:0] result
);

    localparam int PTR_W = $clog2(TAPE_CELLS);
    localparam logic [PTR_W:0] CELLS_E = (PTR_W+1)'(TAPE_CELLS);

    logic [PTR_W:0] fwd_sum;
    logic [PTR_W:0] fwd_wrap;
    logic [PTR_W:0] bwd_wrap;

    assign fwd_sum  = {1'b0, base} + {1'b0, offset};
    assign fwd_wrap = (fwd_sum >= CELLS_E) ? (fwd_sum - CELLS_E) : fwd_sum;
    assign bwd_wrap = (base >= offset) ? ({1'b0, base} - {1'b0, offset})
                                       : ({1'b0, base} + CELLS_E - {1'b0, offset});

    assign result = backward ? bwd_wrap[PTR_W-1:0] : fwd_wrap[PTR_W-1:0];

endmodule

// File: hdl/bf_op_execution_core.sv
// Top level of the BF op execution core: sequencer, tape memory and output register.
// Depends on bfx_pkg and bfx_ptr_unit.
//
// After reset the core sweeps the tape to zero, one cell per cycle, over all TAPE_CELLS
// cells, and takes no beat meanwhile. It then handles one op at a time: an ordinary
// op passes through accept, tape read, execute and result register, in that order.
// A pointer offset whose magnitude is at least TAPE_CELLS is first reduced on the
// shared multiplier, a reciprocal multiply and then a multiply and subtract. A scan
// reads and then checks each visited cell on the single tape read port, and a move
// that fires adds the target read-modify-write and the source clear. A finished
// result waits in the output register while the next beat is accepted.
module bf_op_execution_core
    import bfx_pkg::*;
#(
    parameter int TAPE_CELLS = 32768
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CMD_W-1:0]    command,
    input  logic signed [ARG_W-1:0] argument,
    input  logic [BYTE_W-1:0]   input_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BYTE_W-1:0]   out_byte,
    output logic [COUNT_W-1:0]  out_count,
    output logic [PC_W-1:0]     next_pc,
    output logic [DPOUT_W-1:0]  data_pointer_now,
    output logic                fault
);

    localparam int PTR_W = $clog2(TAPE_CELLS);
    localparam int CNT_W = $clog2(TAPE_CELLS + 1);
    localparam int RCP_SH = 16 + PTR_W;
    localparam logic [PTR_W:0]   CELLS_E  = (PTR_W+1)'(TAPE_CELLS);
    localparam logic [16:0]      CELLS_17 = 17'(TAPE_CELLS);
    localparam logic [PTR_W-1:0] LAST_CELL = PTR_W'(TAPE_CELLS - 1);
    localparam logic [CNT_W-1:0] FULL_PASS = CNT_W'(TAPE_CELLS);
    localparam logic [63:0]      RCP_NUM  = 64'd1 << RCP_SH;
    localparam logic [16:0]      RCP_MUL  =
        17'((RCP_NUM + 64'(TAPE_CELLS) - 64'd1) / 64'(TAPE_CELLS));

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_REDUCE   = 4'd2;
    localparam logic [3:0] ST_FETCH    = 4'd3;
    localparam logic [3:0] ST_EXEC     = 4'd4;
    localparam logic [3:0] ST_SCAN_RD  = 4'd5;
    localparam logic [3:0] ST_SCAN_CHK = 4'd6;
    localparam logic [3:0] ST_MOVE_RD  = 4'd7;
    localparam logic [3:0] ST_MOVE_WR  = 4'd8;
    localparam logic [3:0] ST_MOVE_CLR = 4'd9;
    localparam logic [3:0] ST_DONE     = 4'd10;

    // Control state
    logic [3:0]       state_reg, state_next;
    logic [PTR_W-1:0] clr_reg, clr_next;
    logic [PTR_W-1:0] dp_reg, dp_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic             out_valid_reg, out_valid_next;

    // Per-op working registers
    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic signed [ARG_W-1:0] arg_reg, arg_next;
    logic [BYTE_W-1:0]       inb_reg, inb_next;
    logic [15:0]             mag_reg, mag_next;
    logic [15:0]             quo_reg, quo_next;
    logic                    red_ph_reg, red_ph_next;
    logic                    neg_reg, neg_next;
    logic [PTR_W-1:0]        scan_p_reg, scan_p_next;
    logic [CNT_W-1:0]        scan_n_reg, scan_n_next;
    logic [PTR_W-1:0]        tgt_reg, tgt_next;
    byte_t                   mv_val_reg, mv_val_next;
    byte_t                   ob_reg, ob_next;
    logic [COUNT_W-1:0]      oc_reg, oc_next;
    logic                    flt_reg, flt_next;
    logic                    jmp_reg, jmp_next;

    // Output register payload
    byte_t                   out_byte_reg, out_byte_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;
    logic [PC_W-1:0]         out_pc_reg, out_pc_next;
    logic [DPOUT_W-1:0]      out_dp_reg, out_dp_next;
    logic                    out_fault_reg, out_fault_next;

    // Tape memory
    byte_t            tape_mem [TAPE_CELLS];
    byte_t            rd_q;
    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    byte_t            mem_wdata;
    logic [PTR_W-1:0] mem_raddr;

    // Shared pointer step
    logic [PTR_W-1:0] step_base;
    logic [PTR_W-1:0] step_out;

    // Shared multiplier for the offset reduction
    logic [15:0] mul_a;
    logic [16:0] mul_b;
    logic [32:0] mul_p;

    logic [15:0] arg_abs;
    logic        arg_pos;
    logic        is_ptr_op;
    logic        in_beat;
    logic        out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign arg_abs   = argument[ARG_W-1] ? (~argument + 16'd1) : argument;
    assign arg_pos   = !arg_reg[ARG_W-1] && (arg_reg != '0);
    assign is_ptr_op = (command == CMD_PTR_INC) || (command == CMD_PTR_DEC) ||
                       (command == CMD_SCAN) || (command == CMD_MOVE);

    assign mul_a = red_ph_reg ? mag_reg : quo_reg;
    assign mul_b = red_ph_reg ? RCP_MUL : CELLS_17;
    assign mul_p = {17'd0, mul_a} * {16'd0, mul_b};

    assign step_base = (state_reg == ST_SCAN_CHK) ? scan_p_reg : dp_reg;

    bfx_ptr_unit #(
        .TAPE_CELLS (TAPE_CELLS)
    ) u_ptr (
        .base     (step_base),
        .offset   (mag_reg[PTR_W-1:0]),
        .backward (neg_reg),
        .result   (step_out)
    );

    always_comb
    begin
        case (state_reg)
            ST_SCAN_RD: mem_raddr = scan_p_reg;
            ST_MOVE_RD: mem_raddr = tgt_reg;
            default:    mem_raddr = dp_reg;
        endcase
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = dp_reg;
        mem_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
            end
            ST_EXEC:
            begin
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rd_q + arg_reg[BYTE_W-1:0];
                    end
                    CMD_SUB:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rd_q - arg_reg[BYTE_W-1:0];
                    end
                    CMD_READ:
                    begin
                        mem_we    = arg_pos;
                        mem_wdata = inb_reg;
                    end
                    CMD_ZERO:
                    begin
                        mem_we = 1'b1;
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
            end
            ST_MOVE_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = tgt_reg;
                mem_wdata = rd_q + mv_val_reg;
            end
            ST_MOVE_CLR:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tape_mem[mem_waddr] <= mem_wdata;
        end
        rd_q <= tape_mem[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        dp_next        = dp_reg;
        pc_next        = pc_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        arg_next       = arg_reg;
        inb_next       = inb_reg;
        mag_next       = mag_reg;
        quo_next       = quo_reg;
        red_ph_next    = red_ph_reg;
        neg_next       = neg_reg;
        scan_p_next    = scan_p_reg;
        scan_n_next    = scan_n_reg;
        tgt_next       = tgt_reg;
        mv_val_next    = mv_val_reg;
        ob_next        = ob_reg;
        oc_next        = oc_reg;
        flt_next       = flt_reg;
        jmp_next       = jmp_reg;
        out_byte_next  = out_byte_reg;
        out_count_next = out_count_reg;
        out_pc_next    = out_pc_reg;
        out_dp_next    = out_dp_reg;
        out_fault_next = out_fault_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_CELL)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    cmd_next    = command;
                    arg_next    = argument;
                    inb_next    = input_byte;
                    mag_next    = arg_abs;
                    red_ph_next = 1'b1;
                    neg_next    = (command == CMD_PTR_DEC) ?
                                  (!argument[ARG_W-1] && (argument != '0)) :
                                  argument[ARG_W-1];
                    ob_next     = '0;
                    oc_next     = '0;
                    flt_next    = 1'b0;
                    jmp_next    = 1'b0;
                    if (is_ptr_op && ({1'b0, arg_abs} >= CELLS_17))
                    begin
                        state_next = ST_REDUCE;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (red_ph_reg)
                begin
                    quo_next    = 16'(mul_p >> RCP_SH);
                    red_ph_next = 1'b0;
                end
                else
                begin
                    mag_next   = mag_reg - mul_p[15:0];
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (cmd_reg)
                    CMD_PTR_INC, CMD_PTR_DEC:
                    begin
                        dp_next = step_out;
                    end
                    CMD_WRITE:
                    begin
                        if (arg_pos)
                        begin
                            ob_next = rd_q;
                            oc_next = arg_reg[COUNT_W-1:0];
                        end
                    end
                    CMD_SCAN:
                    begin
                        if (rd_q != '0)
                        begin
                            scan_p_next = step_out;
                            scan_n_next = CNT_W'(1);
                            state_next  = ST_SCAN_RD;
                        end
                    end
                    CMD_MOVE:
                    begin
                        if (rd_q != '0)
                        begin
                            tgt_next    = step_out;
                            mv_val_next = rd_q;
                            state_next  = ST_MOVE_RD;
                        end
                    end
                    CMD_JZ:
                    begin
                        jmp_next = (rd_q == '0);
                    end
                    CMD_JNZ:
                    begin
                        jmp_next = (rd_q != '0);
                    end
                    CMD_ADD, CMD_SUB, CMD_READ, CMD_ZERO:
                    begin
                        flt_next = 1'b0;
                    end
                    default:
                    begin
                        flt_next = 1'b1;
                    end
                endcase
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (rd_q == '0)
                begin
                    dp_next    = scan_p_reg;
                    state_next = ST_DONE;
                end
                else if (scan_n_reg == FULL_PASS)
                begin
                    flt_next   = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_p_next = step_out;
                    scan_n_next = scan_n_reg + 1'b1;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_MOVE_RD:
            begin
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR:
            begin
                state_next = ST_MOVE_CLR;
            end
            ST_MOVE_CLR:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    if (flt_reg)
                    begin
                        pc_next = pc_reg;
                    end
                    else if (jmp_reg)
                    begin
                        pc_next = $unsigned(arg_reg) + 16'd1;
                    end
                    else
                    begin
                        pc_next = pc_reg + 16'd1;
                    end
                    out_valid_next = 1'b1;
                    out_byte_next  = ob_reg;
                    out_count_next = oc_reg;
                    out_pc_next    = pc_next;
                    out_dp_next    = DPOUT_W'(dp_reg);
                    out_fault_next = flt_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            dp_reg        <= '0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            dp_reg        <= dp_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        arg_reg       <= arg_next;
        inb_reg       <= inb_next;
        mag_reg       <= mag_next;
        quo_reg       <= quo_next;
        red_ph_reg    <= red_ph_next;
        neg_reg       <= neg_next;
        scan_p_reg    <= scan_p_next;
        scan_n_reg    <= scan_n_next;
        tgt_reg       <= tgt_next;
        mv_val_reg    <= mv_val_next;
        ob_reg        <= ob_next;
        oc_reg        <= oc_next;
        flt_reg       <= flt_next;
        jmp_reg       <= jmp_next;
        out_byte_reg  <= out_byte_next;
        out_count_reg <= out_count_next;
        out_pc_reg    <= out_pc_next;
        out_dp_reg    <= out_dp_next;
        out_fault_reg <= out_fault_next;
    end

    assign out_valid        = out_valid_reg;
    assign out_byte         = out_byte_reg;
    assign out_count        = out_count_reg;
    assign next_pc          = out_pc_reg;
    assign data_pointer_now = out_dp_reg;
    assign fault            = out_fault_reg;

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, dp_reg} < CELLS_E)
        else $error("data pointer left the tape");

    a_beat_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> (state_reg == ST_REDUCE) || (state_reg == ST_FETCH))
        else $error("accepted beat did not start an op");

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_CHK) |-> (scan_n_reg <= FULL_PASS) && (scan_n_reg != '0))
        else $error("scan count out of range");

    a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) && (!out_valid_reg || out_ready)
            |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("finished op did not reach the output register");

    a_pc_holds_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && flt_reg |=> pc_reg == $past(pc_reg))
        else $error("program counter advanced on a fault");

endmodule
